// ----- design/tri2d_pkg.sv -----
`timescale 1ns / 1ps

package tri2d_pkg;

  // anchor coordinate and range width
  localparam int D_W    = 16;
  // multiplier operand (coefficients, coordinates, ranges)
  localparam int Q_W    = 18;
  // accumulator of the serial multiplier
  localparam int ACC_W  = 56;
  // right-hand side, determinant and numerator widths
  localparam int B_W    = 36;
  localparam int DET_W  = 38;
  localparam int NUM_W  = 56;
  // result width
  localparam int POS_W  = 32;
  // config port
  localparam int CFG_W  = 18;
  localparam int CIDX_W = 3;

  typedef enum logic [CIDX_W-1:0] {
    REG_ANCHOR0_X = 3'd0,
    REG_ANCHOR0_Y = 3'd1,
    REG_ANCHOR1_X = 3'd2,
    REG_ANCHOR1_Y = 3'd3,
    REG_ANCHOR2_X = 3'd4,
    REG_ANCHOR2_Y = 3'd5,
    REG_RANGE_LIM = 3'd6
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RANGE_LIM_RESET = 18'd6000;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [DET_W-1:0] den;
    logic                    start;
  } div_req_t;

endpackage

// ----- design/tri2d_div.sv -----
`timescale 1ns / 1ps

module tri2d_div #(
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tri2d_pkg::div_req_t             req,
  output logic                            done,
  output logic signed [tri2d_pkg::POS_W-1:0] quo
);
  import tri2d_pkg::*;

  localparam int DVD_W = NUM_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic               running;
  logic [CNT_W-1:0]   cnt;
  logic [DVD_W-1:0]   dvd;
  logic [DET_W-1:0]   rem;
  logic [DET_W-1:0]   den_mag;
  logic [POS_W:0]     q;
  logic               ovf;
  logic               neg;

  logic [NUM_W-1:0]   num_mag;
  logic [DET_W-1:0]   den_abs;
  logic [DET_W:0]     trial;
  logic               ge;
  logic [DET_W:0]     diff;
  logic [POS_W:0]     q_next;
  logic               lim_hit;

  always_comb begin
    num_mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    den_abs = req.den[DET_W-1] ? DET_W'(-req.den) : DET_W'(req.den);
    trial   = {rem, dvd[DVD_W-1]};
    ge      = trial >= {1'b0, den_mag};
    diff    = trial - {1'b0, den_mag};
    q_next  = {q[POS_W-1:0], ge};
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DVD_W);
        dvd     <= DVD_W'(num_mag) << FRAC_BITS;
        den_mag <= den_abs;
        rem     <= '0;
        q       <= '0;
        ovf     <= 1'b0;
        neg     <= req.num[NUM_W-1] ^ req.den[DET_W-1];
      end else if (running) begin
        dvd <= dvd << 1;
        rem <= ge ? diff[DET_W-1:0] : trial[DET_W-1:0];
        q   <= q_next;
        ovf <= ovf | q[POS_W];
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    lim_hit = ovf || (neg ? (q > {2'b01, {(POS_W-1){1'b0}}})
                          : (q > {2'b00, {(POS_W-1){1'b1}}}));
    if (lim_hit) begin
      quo = neg ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      quo = neg ? -q[POS_W-1:0] : q[POS_W-1:0];
    end
  end

endmodule

// ----- design/three_anchor_trilateration_2d.sv -----
`timescale 1ns / 1ps

// channel  | signals                              | direction
// ---------+--------------------------------------+----------
// input    | in_valid, in_stall, rx_byte          | in
// result   | out_valid, out_stall, pos_x, pos_y,  | out
//          | status                               |
// config   | cfg_wr_en, cfg_index, cfg_data       | in
//
// one byte per cycle is taken while in_stall is low; a frame end starts a solve: a range
// gate state, the multiply-accumulate program on the bit-serial multiplier, then an x and
// a y quotient from the bit-serial divider.
// bytes of the next frame keep flowing during a solve; only its last byte stalls.
// reset is synchronous: byte count, sequencer and config registers go to their reset values.
// a result waits in the output register until taken; out_stall holds it.
module three_anchor_trilateration_2d #(
  parameter int FRAME_BYTES = 9,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            rx_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tri2d_pkg::POS_W-1:0]    pos_x,
  output logic signed [tri2d_pkg::POS_W-1:0]    pos_y,
  output logic                                  status,
  input  logic                                  cfg_wr_en,
  input  logic [tri2d_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [tri2d_pkg::CFG_W-1:0]           cfg_data
);
  import tri2d_pkg::*;

  localparam int OP_N  = 18;
  localparam int OP_W  = $clog2(OP_N);
  localparam int BIT_W = $clog2(Q_W);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GATE = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIVX = 6'b001000,
    S_DIVY = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    OP_D0, OP_D1, OP_D2, OP_X0, OP_Y0, OP_X1, OP_Y1, OP_X2, OP_Y2,
    OP_A00, OP_A01, OP_A10, OP_A11, OP_B0, OP_B1
  } opnd_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_B0, DST_B1, DST_DET, DST_NUMX, DST_NUMY
  } dest_t;

  typedef struct packed {
    opnd_t p;
    opnd_t q;
    logic  sub;
    logic  first;
    dest_t dest;
  } op_t;

  // multiply-accumulate program: b0, b1, det, x numerator, y numerator
  function automatic op_t op_info(input logic [OP_W-1:0] k);
    op_t o;
    o = '{p: OP_D0, q: OP_D0, sub: 1'b0, first: 1'b0, dest: DST_NONE};
    unique case (k)
      5'd0:  o = '{OP_D0,  OP_D0,  1'b0, 1'b1, DST_NONE};
      5'd1:  o = '{OP_D1,  OP_D1,  1'b1, 1'b0, DST_NONE};
      5'd2:  o = '{OP_X0,  OP_X0,  1'b1, 1'b0, DST_NONE};
      5'd3:  o = '{OP_X1,  OP_X1,  1'b0, 1'b0, DST_NONE};
      5'd4:  o = '{OP_Y0,  OP_Y0,  1'b1, 1'b0, DST_NONE};
      5'd5:  o = '{OP_Y1,  OP_Y1,  1'b0, 1'b0, DST_B0};
      5'd6:  o = '{OP_D0,  OP_D0,  1'b0, 1'b1, DST_NONE};
      5'd7:  o = '{OP_D2,  OP_D2,  1'b1, 1'b0, DST_NONE};
      5'd8:  o = '{OP_X0,  OP_X0,  1'b1, 1'b0, DST_NONE};
      5'd9:  o = '{OP_X2,  OP_X2,  1'b0, 1'b0, DST_NONE};
      5'd10: o = '{OP_Y0,  OP_Y0,  1'b1, 1'b0, DST_NONE};
      5'd11: o = '{OP_Y2,  OP_Y2,  1'b0, 1'b0, DST_B1};
      5'd12: o = '{OP_A00, OP_A11, 1'b0, 1'b1, DST_NONE};
      5'd13: o = '{OP_A01, OP_A10, 1'b1, 1'b0, DST_DET};
      5'd14: o = '{OP_B0,  OP_A11, 1'b0, 1'b1, DST_NONE};
      5'd15: o = '{OP_B1,  OP_A01, 1'b1, 1'b0, DST_NUMX};
      5'd16: o = '{OP_B1,  OP_A00, 1'b0, 1'b1, DST_NONE};
      5'd17: o = '{OP_B0,  OP_A10, 1'b1, 1'b0, DST_NUMY};
      default: o = '{OP_D0, OP_D0, 1'b0, 1'b0, DST_NONE};
    endcase
    return o;
  endfunction

  // config registers
  logic signed [D_W-1:0] x0, y0, x1, y1, x2, y2;
  logic [CFG_W-1:0]      range_lim;

  // frame capture
  logic [3:0]            byte_index;
  logic [7:0]            range_bytes [6];
  logic [7:0]            rb_cur [6];
  logic                  in_acc;
  logic                  frame_end;
  logic [D_W-1:0]        d0, d1, d2;

  // solve datapath
  state_t                state;
  logic [OP_W-1:0]       op;
  logic [BIT_W-1:0]      bitn;
  logic signed [ACC_W-1:0] acc, acc_next, pshift, term, p_val, base;
  logic [Q_W-1:0]        q_val;
  logic signed [B_W-1:0]   b0, b1;
  logic signed [DET_W-1:0] det;
  logic signed [NUM_W-1:0] numx, numy;
  logic signed [Q_W-1:0]   a00, a01, a10, a11;
  logic                  neg;
  logic                  last_bit, last_op;
  op_t                   cur;
  div_req_t              div_req;
  logic                  div_done;
  logic signed [POS_W-1:0] div_quo;
  logic [CFG_W-1:0]      range_sum;

  // config writes; index 7 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      x0 <= '0; y0 <= '0; x1 <= '0; y1 <= '0; x2 <= '0; y2 <= '0;
      range_lim <= RANGE_LIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ANCHOR0_X: x0 <= cfg_data[D_W-1:0];
        REG_ANCHOR0_Y: y0 <= cfg_data[D_W-1:0];
        REG_ANCHOR1_X: x1 <= cfg_data[D_W-1:0];
        REG_ANCHOR1_Y: y1 <= cfg_data[D_W-1:0];
        REG_ANCHOR2_X: x2 <= cfg_data[D_W-1:0];
        REG_ANCHOR2_Y: y2 <= cfg_data[D_W-1:0];
        REG_RANGE_LIM: range_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  // only the last byte of a frame waits, while a solve runs or its result is untaken
  assign frame_end = byte_index >= 4'(FRAME_BYTES - 1);
  assign in_stall  = (state != S_IDLE) && frame_end;
  assign in_acc    = in_valid && !in_stall;

  // range bytes sit at frame bytes 3..8; the incoming byte is forwarded
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      rb_cur[i] = (in_acc && byte_index == 4'(i + 3)) ? rx_byte : range_bytes[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      range_bytes[i] <= rb_cur[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (in_acc) begin
      byte_index <= frame_end ? 4'd0 : byte_index + 4'd1;
    end
  end

  // linearized coefficients, 2*(xi - x0) and so on
  assign a00 = {17'({x1[D_W-1], x1} - {x0[D_W-1], x0}), 1'b0};
  assign a01 = {17'({y1[D_W-1], y1} - {y0[D_W-1], y0}), 1'b0};
  assign a10 = {17'({x2[D_W-1], x2} - {x0[D_W-1], x0}), 1'b0};
  assign a11 = {17'({y2[D_W-1], y2} - {y0[D_W-1], y0}), 1'b0};

  // operand select for the serial multiplier
  always_comb begin
    cur = op_info(op);
    unique case (cur.p)
      OP_D0:  p_val = ACC_W'(d0);
      OP_D1:  p_val = ACC_W'(d1);
      OP_D2:  p_val = ACC_W'(d2);
      OP_X0:  p_val = {{(ACC_W-D_W){x0[D_W-1]}}, x0};
      OP_Y0:  p_val = {{(ACC_W-D_W){y0[D_W-1]}}, y0};
      OP_X1:  p_val = {{(ACC_W-D_W){x1[D_W-1]}}, x1};
      OP_Y1:  p_val = {{(ACC_W-D_W){y1[D_W-1]}}, y1};
      OP_X2:  p_val = {{(ACC_W-D_W){x2[D_W-1]}}, x2};
      OP_Y2:  p_val = {{(ACC_W-D_W){y2[D_W-1]}}, y2};
      OP_A00: p_val = {{(ACC_W-Q_W){a00[Q_W-1]}}, a00};
      OP_A01: p_val = {{(ACC_W-Q_W){a01[Q_W-1]}}, a01};
      OP_A10: p_val = {{(ACC_W-Q_W){a10[Q_W-1]}}, a10};
      OP_A11: p_val = {{(ACC_W-Q_W){a11[Q_W-1]}}, a11};
      OP_B0:  p_val = {{(ACC_W-B_W){b0[B_W-1]}}, b0};
      OP_B1:  p_val = {{(ACC_W-B_W){b1[B_W-1]}}, b1};
      default: p_val = '0;
    endcase
    unique case (cur.q)
      OP_D0:  q_val = Q_W'(d0);
      OP_D1:  q_val = Q_W'(d1);
      OP_D2:  q_val = Q_W'(d2);
      OP_X0:  q_val = {{(Q_W-D_W){x0[D_W-1]}}, x0};
      OP_Y0:  q_val = {{(Q_W-D_W){y0[D_W-1]}}, y0};
      OP_X1:  q_val = {{(Q_W-D_W){x1[D_W-1]}}, x1};
      OP_Y1:  q_val = {{(Q_W-D_W){y1[D_W-1]}}, y1};
      OP_X2:  q_val = {{(Q_W-D_W){x2[D_W-1]}}, x2};
      OP_Y2:  q_val = {{(Q_W-D_W){y2[D_W-1]}}, y2};
      OP_A00: q_val = a00;
      OP_A01: q_val = a01;
      OP_A10: q_val = a10;
      OP_A11: q_val = a11;
      default: q_val = '0;
    endcase
  end

  // one multiplier bit per cycle; the top bit of the signed operand subtracts
  always_comb begin
    last_bit = bitn == BIT_W'(Q_W - 1);
    last_op  = op == OP_W'(OP_N - 1);
    term     = (bitn == '0) ? p_val : pshift;
    base     = (cur.first && bitn == '0) ? '0 : acc;
    neg      = cur.sub ^ last_bit;
    if (q_val[bitn]) begin
      acc_next = neg ? base - term : base + term;
    end else begin
      acc_next = base;
    end
  end

  assign range_sum = CFG_W'(d0) + CFG_W'(d1) + CFG_W'(d2);

  always_comb begin
    div_req.num   = (state == S_DIVX) ? numy : numx;
    div_req.den   = det;
    div_req.start = (state == S_MUL && last_bit && last_op && det != '0) ||
                    (state == S_DIVX && div_done);
  end

  tri2d_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  // solve sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= '0;
      bitn  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc && frame_end) begin
            d0    <= {rb_cur[1], rb_cur[0]};
            d1    <= {rb_cur[3], rb_cur[2]};
            d2    <= {rb_cur[5], rb_cur[4]};
            state <= S_GATE;
          end
        end
        S_GATE: begin
          op   <= '0;
          bitn <= '0;
          // over the range gate: frame dropped, no transaction
          state <= (range_sum > range_lim) ? S_IDLE : S_MUL;
        end
        S_MUL: begin
          acc    <= acc_next;
          pshift <= term <<< 1;
          if (last_bit) begin
            bitn <= '0;
            op   <= op + 1'b1;
            unique case (cur.dest)
              DST_B0:   b0   <= acc_next[B_W-1:0];
              DST_B1:   b1   <= acc_next[B_W-1:0];
              DST_DET:  det  <= acc_next[DET_W-1:0];
              DST_NUMX: numx <= acc_next[NUM_W-1:0];
              DST_NUMY: numy <= acc_next[NUM_W-1:0];
              default: ;
            endcase
            if (last_op) begin
              if (det == '0) begin
                // collinear anchors
                pos_x  <= '0;
                pos_y  <= '0;
                status <= 1'b1;
                state  <= S_OUT;
              end else begin
                state <= S_DIVX;
              end
            end
          end else begin
            bitn <= bitn + 1'b1;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            pos_x <= div_quo;
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            pos_y  <= div_quo;
            status <= 1'b0;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = state == S_OUT;

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> state != S_IDLE)
    else $error("input stalled while idle");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && frame_end) |=> state == S_GATE)
    else $error("frame end did not start a solve");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (pos_x == '0 && pos_y == '0))
    else $error("singular result with nonzero position");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVX || state == S_DIVY))
    else $error("divider finished outside a divide phase");

endmodule

// ----- dv/trilat_checker.sv -----
`timescale 1ns / 1ps

module trilat_checker #(
  parameter int FRAME_BYTES = 9,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [7:0]                          rx_byte,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [tri2d_pkg::POS_W-1:0]  pos_x,
  input  logic signed [tri2d_pkg::POS_W-1:0]  pos_y,
  input  logic                                status,
  input  logic                                cfg_wr_en,
  input  logic [tri2d_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [tri2d_pkg::CFG_W-1:0]         cfg_data,
  output int                                  errors,
  output int                                  pending
);
  import tri2d_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    st;
  } fix_t;

  fix_t fix_q[$];

  logic signed [15:0] anc_x [3];
  logic signed [15:0] anc_y [3];
  logic [CFG_W-1:0]   sum_lim;
  logic [3:0]         frame_pos;
  logic [7:0]         rng_b [6];

  // trunc(num * 2^FRAC_BITS / den), saturated to 32 bits
  function automatic longint scaled_quot(longint num, longint den);
    longint q;
    longint r;
    longint v;
    q = num / den;
    r = num % den;
    if (q > (longint'(1) << 33)) return 64'sd2147483647;
    if (q < -(longint'(1) << 33)) return -64'sd2147483648;
    v = q * (longint'(1) << FRAC_BITS) + (r * (longint'(1) << FRAC_BITS)) / den;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // solve the linearized 2x2 system for one frame; returns 0 if gated out
  function automatic bit solve_fix(output fix_t f);
    longint d [3];
    longint ax [3];
    longint ay [3];
    longint a [2][2];
    longint b [2];
    longint det;
    for (int i = 0; i < 3; i++) begin
      d[i]  = longint'({rng_b[2*i+1], rng_b[2*i]});
      ax[i] = longint'(anc_x[i]);
      ay[i] = longint'(anc_y[i]);
    end
    if (d[0] + d[1] + d[2] > longint'(sum_lim)) return 0;
    for (int i = 0; i < 2; i++) begin
      a[i][0] = -2 * (ax[0] - ax[i+1]);
      a[i][1] = -2 * (ay[0] - ay[i+1]);
      b[i] = (d[0]*d[0] - d[i+1]*d[i+1]) - (ax[0]*ax[0] - ax[i+1]*ax[i+1])
           - (ay[0]*ay[0] - ay[i+1]*ay[i+1]);
    end
    det = a[0][0]*a[1][1] - a[0][1]*a[1][0];
    if (det == 0) begin
      f.x = '0;
      f.y = '0;
      f.st = 1'b1;
    end else begin
      f.x = POS_W'(scaled_quot(b[0]*a[1][1] - a[0][1]*b[1], det));
      f.y = POS_W'(scaled_quot(a[0][0]*b[1] - a[1][0]*b[0], det));
      f.st = 1'b0;
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    fix_t f;
    fix_t e;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        anc_x[i] = '0;
        anc_y[i] = '0;
      end
      sum_lim   = RANGE_LIM_RESET;
      frame_pos = '0;
      for (int i = 0; i < 6; i++) rng_b[i] = '0;
      fix_q.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ANCHOR0_X: anc_x[0] = cfg_data[15:0];
          REG_ANCHOR0_Y: anc_y[0] = cfg_data[15:0];
          REG_ANCHOR1_X: anc_x[1] = cfg_data[15:0];
          REG_ANCHOR1_Y: anc_y[1] = cfg_data[15:0];
          REG_ANCHOR2_X: anc_x[2] = cfg_data[15:0];
          REG_ANCHOR2_Y: anc_y[2] = cfg_data[15:0];
          REG_RANGE_LIM: sum_lim  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (frame_pos >= 3 && frame_pos <= 8) rng_b[frame_pos-3] = rx_byte;
        if (frame_pos >= FRAME_BYTES - 1) begin
          frame_pos = '0;
          if (solve_fix(f)) fix_q.push_back(f);
        end else begin
          frame_pos = frame_pos + 1'b1;
        end
      end
      if (out_valid && !out_stall) begin
        if (fix_q.size() == 0) begin
          $error("unexpected result transaction x=%0d y=%0d status=%0d",
                 pos_x, pos_y, status);
          errors++;
        end else begin
          e = fix_q.pop_front();
          if (pos_x !== e.x) begin
            $error("pos_x mismatch: expected %0d actual %0d", e.x, pos_x);
            errors++;
          end
          if (pos_y !== e.y) begin
            $error("pos_y mismatch: expected %0d actual %0d", e.y, pos_y);
            errors++;
          end
          if (status !== e.st) begin
            $error("status mismatch: expected %0d actual %0d", e.st, status);
            errors++;
          end
        end
      end
    end
    pending = fix_q.size();
  end
endmodule

// ----- dv/tb_three_anchor_trilateration_2d.sv -----
`timescale 1ns / 1ps

module tb_three_anchor_trilateration_2d;
  import tri2d_pkg::*;

  // index with no register behind it, writes are dropped
  localparam logic [CIDX_W-1:0] REG_NONE = 3'd7;
  localparam int LIM_MAX   = 196605;
  localparam int SETTLE    = 700;    // longer than one solve
  localparam int WDOG_MAX  = 20000;
  localparam int HOLD_LEN  = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic status;
  logic cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int errors;
  int pending;

  // idling percentages for sender and receiver
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // toggled by stimulus to ask the receiver for one long hold-off
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  three_anchor_trilateration_2d u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .status(status),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  trilat_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .status(status),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // receiver: random stalls, or a long counted hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one byte transaction; valid stays up while stalled
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // nine-byte frame: three random header bytes, then little-endian ranges
  task automatic send_frame(input logic [15:0] d0, input logic [15:0] d1,
                            input logic [15:0] d2);
    logic [7:0] fb [9];
    fb[0] = 8'($urandom);
    fb[1] = 8'($urandom);
    fb[2] = 8'($urandom);
    {fb[4], fb[3]} = d0;
    {fb[6], fb[5]} = d1;
    {fb[8], fb[7]} = d2;
    for (int i = 0; i < 9; i++) send_byte(fb[i]);
  endtask

  // writes all registers back to back, plus one dropped write
  task automatic set_regs(input logic signed [15:0] x0, input logic signed [15:0] y0,
                          input logic signed [15:0] x1, input logic signed [15:0] y1,
                          input logic signed [15:0] x2, input logic signed [15:0] y2,
                          input logic [CFG_W-1:0] lim);
    logic [15:0] anc [6];
    anc = '{x0, y0, x1, y1, x2, y2};
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CIDX_W'(i);
      // upper bits are don't-care for the 16-bit registers
      cfg_data  <= {2'($urandom_range(3)), anc[i]};
      @(posedge clk);
    end
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_RANGE_LIM;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_NONE;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender pauses until every result is back, then lets a dropped solve finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] c [6];
    logic [CFG_W-1:0] lim;
    int third;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset anchors are all at the origin, so solves are singular
    send_frame(16'd2000, 16'd2000, 16'd2001);   // sum one over the gate
    send_frame(16'd0, 16'd0, 16'd0);            // singular result
    drain();
    // unit anchors with one full range drive the quotient into saturation
    set_regs(16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1, CFG_W'(LIM_MAX));
    send_frame(16'hffff, 16'd0, 16'd0);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      for (int i = 0; i < 6; i++) c[i] = 16'($urandom);
      lim = CFG_W'($urandom_range(LIM_MAX));
      case (ph)
        1: begin
          // corner anchors
          c = '{-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
                -16'sd32768, 16'sd32767};
          lim = CFG_W'(LIM_MAX);
        end
        0: lim = CFG_W'(LIM_MAX);
        3: begin
          // collinear anchors
          c = '{16'sd100, 16'sd200, 16'sd300, 16'sd400, -16'sd500, -16'sd400};
          lim = 18'd30000;
        end
        4: lim = '0;
        default: ;
      endcase
      set_regs(c[0], c[1], c[2], c[3], c[4], c[5], lim);
      send_idle_pct  = (ph % 4 == 1) ? 62 : (ph % 4 == 3) ? 24 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 62 : (ph % 4 == 3) ? 24 : 0;
      // long receiver hold-off while frames keep coming
      if (ph == 2 || ph == 6) hold_req <= ~hold_req;
      third = int'(lim) / 3;
      for (int f = 0; f < 8; f++) begin
        if ($urandom_range(99) < 80) begin
          send_frame(16'($urandom_range(third)), 16'($urandom_range(third)),
                     16'($urandom_range(third)));
        end else begin
          send_frame(16'($urandom), 16'($urandom), 16'($urandom));
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
